// ----- hw/rtl/spcp_pkg.sv -----
// Shared types and constants for the spline camera path player.
package spcp_pkg;

    // Transaction kinds on the input channel
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Width of the six-times-scaled control values inside a lane
    localparam int VW = 37;

    // Quotient bits produced per divider step
    localparam int DIG_W = 16;

    // Number of lanes: eye x, y, z then look-at x, y, z
    localparam int NUM_LANES = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_WRAP,
        ST_RD,
        ST_RDW,
        ST_CTRL,
        ST_DIFF,
        ST_MUL,
        ST_DLD,
        ST_DIV,
        ST_WB,
        ST_FLD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic       append;
        logic       clear;
        logic       norm_ld;
        logic       norm_step;
        logic       wrap;
        logic       rd_en;
        logic [1:0] rd_slot;
        logic       ctrl_ld;
        logic       diff;
        logic       mul;
        logic       div_ld;
        logic       div_fin_ld;
        logic       div_step;
        logic       wb;
        logic [1:0] sel;
        logic       out_ld;
        logic       out_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic short_path;
        logic norm_done;
        logic div_last;
    } t_dp_stat;

    // Left point of the pair used by each de Casteljau lerp, in order
    function automatic logic [1:0] lerp_sel(input logic [2:0] j);
        logic [1:0] s;
        case (j) inside
            3'd0, 3'd3, 3'd5: s = 2'd0;
            3'd1, 3'd4:       s = 2'd1;
            3'd2:             s = 2'd2;
            default:          s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/spline_camera_path_player.sv -----
// Top level of the spline camera path player: controller plus datapath.
// One transaction at a time. Append, clear and dropped kinds finish in IDLE; a tick on a path
// with fewer than two points goes straight to the output state. A full tick normalises the path
// position, wraps it, gathers four points, then runs six lerps and the final divide by six,
// each a digit-serial divide of PW = 39 + clog2(STEPS) bits, DIG_W quotient bits per step.
// Synchronous active-low reset clears point count, path position and all handshakes.
module spline_camera_path_player
    import spcp_pkg::*;
#(
    parameter int MAX_POINTS        = 64,
    parameter int STEPS_PER_SEGMENT = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [4:0]  i_step,
    input  logic signed [31:0] i_eye_x_in,
    input  logic signed [31:0] i_eye_y_in,
    input  logic signed [31:0] i_eye_z_in,
    input  logic signed [31:0] i_look_x_in,
    input  logic signed [31:0] i_look_y_in,
    input  logic signed [31:0] i_look_z_in,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic [5:0]         o_segment_index,
    output logic signed [31:0] o_eye_x_out,
    output logic signed [31:0] o_eye_y_out,
    output logic signed [31:0] o_eye_z_out,
    output logic signed [31:0] o_look_x_out,
    output logic signed [31:0] o_look_y_out,
    output logic signed [31:0] o_look_z_out
);

    t_dp_cmd                    cmd;
    t_dp_stat                   stat;
    logic [NUM_LANES-1:0][31:0] pt;
    logic [NUM_LANES-1:0][31:0] coord;

    // Lane order: eye x, y, z then look-at x, y, z
    assign pt = {i_look_z_in, i_look_y_in, i_look_x_in, i_eye_z_in, i_eye_y_in, i_eye_x_in};

    // Controller: accepts one transaction at a time and holds a finished
    // result in the output register until the consumer takes it
    spcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Datapath: point store, position counter, six coordinate lanes
    spcp_dpath #(
        .MAX_POINTS        (MAX_POINTS),
        .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_step          (i_step),
        .i_pt            (pt),
        .o_status        (o_status),
        .o_segment_index (o_segment_index),
        .o_coord         (coord)
    );

    assign o_eye_x_out  = coord[0];
    assign o_eye_y_out  = coord[1];
    assign o_eye_z_out  = coord[2];
    assign o_look_x_out = coord[3];
    assign o_look_y_out = coord[4];
    assign o_look_z_out = coord[5];

endmodule

// ----- hw/rtl/spcp_lane.sv -----
// One coordinate lane: control values, shared lerp multiplier and constant divider.
module spcp_lane
    import spcp_pkg::*;
#(
    parameter int STEPS_PER_SEGMENT = 100
) (
    input  logic                                    i_clk,
    input  t_dp_cmd                                 i_cmd,
    input  logic                                    i_pt_we,
    input  logic [1:0]                              i_pt_slot,
    input  logic signed [31:0]                      i_pt,
    input  logic [$clog2(STEPS_PER_SEGMENT)-1:0]    i_r,
    input  logic                                    i_first,
    input  logic                                    i_last,
    output logic signed [31:0]                      o_out
);

    localparam int RBW = $clog2(STEPS_PER_SEGMENT);
    localparam int DW  = VW + 1;
    localparam int PW  = VW + 2 + RBW;
    localparam int NCH = (PW + DIG_W - 1) / DIG_W;
    localparam int XW  = NCH * DIG_W;
    // Remainder bits for each divisor, and the wider of the two
    localparam int SBS = $clog2(STEPS_PER_SEGMENT);
    localparam int SB6 = 3;
    localparam int SB  = (SBS > SB6) ? SBS : SB6;
    localparam int YW  = DIG_W + SB;
    localparam int MW  = YW + 2;
    // Reciprocals, exact for a remainder followed by one digit
    localparam int KS  = DIG_W + 2 * SBS;
    localparam int K6  = DIG_W + 2 * SB6;
    localparam longint MS = ((longint'(1) << KS) + longint'(STEPS_PER_SEGMENT) - 1)
                            / longint'(STEPS_PER_SEGMENT);
    localparam longint M6 = ((longint'(1) << K6) + 5) / 6;

    logic signed [31:0]   r_p0, r_p1, r_p2, r_p3;
    logic signed [VW-1:0] r_v0, r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_diff;
    logic signed [PW-1:0] r_prod;
    logic [XW-1:0]        r_dvd;
    logic [SB-1:0]        r_rem;
    logic                 r_by6;
    logic                 r_neg;
    logic signed [31:0]   r_out;

    logic signed [VW-1:0] q0, q1, qm, q2, c0, c3, d10;
    logic signed [VW-1:0] v_lo, v_hi;
    logic [YW-1:0]        dig_y;
    logic [YW-1:0]        dig_d;
    logic [MW-1:0]        dig_m;
    logic [YW+MW-1:0]     dig_p;
    logic [DIG_W-1:0]     dig_q;
    logic [SB-1:0]        dig_r;
    logic [PW-1:0]        mag_p, mag_f;
    logic signed [PW-1:0] quot;
    logic signed [PW-1:0] fin_x;
    logic signed [31:0]   sat;

    always_comb begin
        q0  = VW'(r_p1);
        q1  = VW'(r_p2);
        qm  = VW'(r_p0);
        q2  = VW'(r_p3);
        c0  = (q0 <<< 2) + (q0 <<< 1);
        c3  = (q1 <<< 2) + (q1 <<< 1);
        d10 = q1 - q0;
        case (i_cmd.sel)
            2'd0:    begin v_lo = r_v0; v_hi = r_v1; end
            2'd1:    begin v_lo = r_v1; v_hi = r_v2; end
            2'd2:    begin v_lo = r_v2; v_hi = r_v3; end
            default: begin v_lo = r_v0; v_hi = r_v1; end
        endcase
        // One quotient digit per step: remainder and next digit times the reciprocal
        dig_y = {r_rem, r_dvd[XW-1 -: DIG_W]};
        dig_d = r_by6 ? YW'(6) : YW'(STEPS_PER_SEGMENT);
        dig_m = r_by6 ? MW'(M6) : MW'(MS);
        dig_p = (YW+MW)'(dig_y) * (YW+MW)'(dig_m);
        dig_q = r_by6 ? dig_p[K6 +: DIG_W] : dig_p[KS +: DIG_W];
        dig_r = SB'(dig_y - YW'(dig_q) * dig_d);
        fin_x = PW'(r_v0) + PW'(3);
        mag_p = r_prod[PW-1] ? ~r_prod : r_prod;
        mag_f = fin_x[PW-1] ? ~fin_x : fin_x;
        quot  = r_neg ? $signed(~r_dvd[PW-1:0]) : $signed(r_dvd[PW-1:0]);
        if (!(|quot[PW-1:31]) || (&quot[PW-1:31])) begin
            sat = quot[31:0];
        end else if (quot[PW-1]) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt_we) begin
            case (i_pt_slot)
                2'd0:    r_p0 <= i_pt;
                2'd1:    r_p1 <= i_pt;
                2'd2:    r_p2 <= i_pt;
                default: r_p3 <= i_pt;
            endcase
        end
        if (i_cmd.ctrl_ld) begin
            r_v0 <= c0;
            r_v1 <= i_first ? c0 + (d10 <<< 1) : c0 + (q1 - qm);
            r_v2 <= i_last  ? c3 - (d10 <<< 1) : c3 - (q2 - q0);
            r_v3 <= c3;
        end
        if (i_cmd.diff) begin
            r_diff <= DW'(v_hi) - DW'(v_lo);
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_diff) * PW'($signed({1'b0, i_r}));
        end
        // Floor division through the magnitude: floor(x/d) = ~floor(~x/d) for x < 0
        if (i_cmd.div_ld || i_cmd.div_fin_ld) begin
            r_neg <= i_cmd.div_ld ? r_prod[PW-1] : fin_x[PW-1];
            r_by6 <= i_cmd.div_fin_ld;
            r_dvd <= i_cmd.div_ld ? XW'(mag_p) : XW'(mag_f);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= dig_r;
            r_dvd <= {r_dvd[XW-DIG_W-1:0], dig_q};
        end
        if (i_cmd.wb) begin
            case (i_cmd.sel)
                2'd0:    r_v0 <= v_lo + VW'(quot);
                2'd1:    r_v1 <= v_lo + VW'(quot);
                default: r_v2 <= v_lo + VW'(quot);
            endcase
        end
        if (i_cmd.out_ld) begin
            r_out <= i_cmd.out_zero ? '0 : sat;
        end
    end

    assign o_out = r_out;

endmodule

// ----- hw/rtl/spcp_dpath.sv -----
// Datapath: point store, path position, read gather and the six coordinate lanes.
module spcp_dpath
    import spcp_pkg::*;
#(
    parameter int MAX_POINTS        = 64,
    parameter int STEPS_PER_SEGMENT = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_dp_cmd                           i_cmd,
    output t_dp_stat                          o_stat,
    input  logic signed [4:0]                 i_step,
    input  logic [NUM_LANES-1:0][31:0]        i_pt,
    output logic                              o_status,
    output logic [5:0]                        o_segment_index,
    output logic [NUM_LANES-1:0][31:0]        o_coord
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SGW = CW + 2;
    localparam int RW  = $clog2(STEPS_PER_SEGMENT + 16) + 1;
    localparam int RBW = $clog2(STEPS_PER_SEGMENT);
    localparam int PW  = VW + 2 + RBW;
    localparam int NCH = (PW + DIG_W - 1) / DIG_W;
    localparam int DCW = $clog2(NCH + 1);

    logic [NUM_LANES*32-1:0] r_mem [MAX_POINTS];
    logic [NUM_LANES*32-1:0] r_rd_data;
    logic                    r_rd_vld;
    logic [1:0]              r_rd_slot;
    logic [CW-1:0]           r_count;
    logic signed [SGW-1:0]   r_seg;
    logic signed [RW-1:0]    r_rem;
    logic [DCW-1:0]          r_dcnt;
    logic                    r_status;
    logic [5:0]              r_segout;

    logic signed [SGW-1:0]   cnt_s;
    logic signed [SGW:0]     addr_s;
    logic [AW-1:0]           rd_addr;
    logic signed [RW-1:0]    steps_s;
    logic                    first, last;

    always_comb begin
        cnt_s   = $signed({2'b00, r_count});
        steps_s = $signed(RW'(STEPS_PER_SEGMENT));
        addr_s  = (SGW+1)'(r_seg) + (SGW+1)'($signed({1'b0, i_cmd.rd_slot})) - (SGW+1)'(1);
        if (addr_s < 0) begin
            addr_s = addr_s + (SGW+1)'(MAX_POINTS);
        end else if (addr_s >= (SGW+1)'(MAX_POINTS)) begin
            addr_s = addr_s - (SGW+1)'(MAX_POINTS);
        end
        rd_addr = addr_s[AW-1:0];
        first   = (r_seg == '0);
        last    = (r_seg + SGW'(2)) >= cnt_s;
        o_stat.short_path = r_count < CW'(2);
        o_stat.norm_done  = (r_rem >= 0) && (r_rem < steps_s);
        o_stat.div_last   = (r_dcnt == DCW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_count < CW'(MAX_POINTS))) begin
            r_mem[r_count[AW-1:0]] <= i_pt;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        r_rd_slot <= i_cmd.rd_slot;
        if (i_cmd.div_ld || i_cmd.div_fin_ld) begin
            r_dcnt <= DCW'(NCH);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd.out_ld) begin
            r_status <= i_cmd.out_zero;
            r_segout <= i_cmd.out_zero ? 6'd0 : 6'(r_seg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_seg    <= '0;
            r_rem    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append && (r_count < CW'(MAX_POINTS))) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.norm_ld) begin
                r_rem <= r_rem + RW'(i_step);
            end else if (i_cmd.norm_step) begin
                if (r_rem < 0) begin
                    r_rem <= r_rem + steps_s;
                    r_seg <= r_seg - SGW'(1);
                end else begin
                    r_rem <= r_rem - steps_s;
                    r_seg <= r_seg + SGW'(1);
                end
            end else if (i_cmd.wrap) begin
                if (r_seg < 0) begin
                    r_seg <= cnt_s - SGW'(2);
                    r_rem <= steps_s - RW'(1);
                end else if (r_seg >= cnt_s - SGW'(1)) begin
                    r_seg <= '0;
                    r_rem <= RW'(1);
                end
            end
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        spcp_lane #(
            .STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
        ) u_lane (
            .i_clk     (i_clk),
            .i_cmd     (i_cmd),
            .i_pt_we   (r_rd_vld),
            .i_pt_slot (r_rd_slot),
            .i_pt      ($signed(r_rd_data[k*32 +: 32])),
            .i_r       (r_rem[RBW-1:0]),
            .i_first   (first),
            .i_last    (last),
            .o_out     (o_coord[k])
        );
    end

    assign o_status        = r_status;
    assign o_segment_index = r_segout;

endmodule

// ----- hw/rtl/spcp_ctrl.sv -----
// Controller: sequences store updates, position update, gather and lerp steps.
module spcp_ctrl
    import spcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_stat   i_stat
);

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_short, n_short;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_short     <= n_short;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_short     = r_short;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_kind)
                        KIND_APPEND: o_cmd.append = 1'b1;
                        KIND_CLEAR:  o_cmd.clear  = 1'b1;
                        KIND_TICK: begin
                            if (i_stat.short_path) begin
                                n_short = 1'b1;
                                n_state = ST_FIN;
                            end else begin
                                n_short      = 1'b0;
                                o_cmd.norm_ld = 1'b1;
                                n_state      = ST_NORM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = ST_WRAP;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_cnt      = '0;
                n_state    = ST_RD;
            end
            ST_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_slot = r_cnt[1:0];
                if (r_cnt == 3'd3) begin
                    n_state = ST_RDW;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_RDW: n_state = ST_CTRL;
            ST_CTRL: begin
                o_cmd.ctrl_ld = 1'b1;
                n_cnt         = '0;
                n_state       = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                o_cmd.sel  = lerp_sel(r_cnt);
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DLD;
            end
            ST_DLD: begin
                o_cmd.div_ld = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = (r_cnt == 3'd6) ? ST_FIN : ST_WB;
                end
            end
            ST_WB: begin
                o_cmd.wb  = 1'b1;
                o_cmd.sel = lerp_sel(r_cnt);
                if (r_cnt == 3'd5) begin
                    n_state = ST_FLD;
                end else begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = ST_DIFF;
                end
            end
            ST_FLD: begin
                o_cmd.div_fin_ld = 1'b1;
                n_cnt            = 3'd6;
                n_state          = ST_DIV;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_zero = r_short;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the spline camera path player.
`timescale 1ns / 100ps

module tb_top
    import spcp_pkg::*;
();

    localparam int NPTS = 64;
    localparam int SEG_STEPS = 100;
    localparam logic [1:0] KIND_NOP = 2'd3; // unused code, must be dropped

    // One result of a tick: status, segment start and six coordinates
    typedef struct packed {
        logic             status;
        logic [5:0]       seg;
        logic [5:0][31:0] crd;
    } t_cam_pose;

    // One row of stimulus; typed rows carry their own expected pose
    typedef struct {
        logic [1:0]       kind;
        logic [4:0]       step;
        logic [5:0][31:0] crd;
        bit               typed;
        t_cam_pose        pose;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic signed [4:0]  i_step;
    logic signed [31:0] i_eye_x_in, i_eye_y_in, i_eye_z_in;
    logic signed [31:0] i_look_x_in, i_look_y_in, i_look_z_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_status;
    logic [5:0]         o_segment_index;
    logic signed [31:0] o_eye_x_out, o_eye_y_out, o_eye_z_out;
    logic signed [31:0] o_look_x_out, o_look_y_out, o_look_z_out;

    spline_camera_path_player u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_step         (i_step),
        .i_eye_x_in     (i_eye_x_in),
        .i_eye_y_in     (i_eye_y_in),
        .i_eye_z_in     (i_eye_z_in),
        .i_look_x_in    (i_look_x_in),
        .i_look_y_in    (i_look_y_in),
        .i_look_z_in    (i_look_z_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_segment_index(o_segment_index),
        .o_eye_x_out    (o_eye_x_out),
        .o_eye_y_out    (o_eye_y_out),
        .o_eye_z_out    (o_eye_z_out),
        .o_look_x_out   (o_look_x_out),
        .o_look_y_out   (o_look_y_out),
        .o_look_z_out   (o_look_z_out)
    );

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the path: lanes are eye x,y,z then look-at x,y,z
    logic signed [31:0] path_pts [6][NPTS];
    int                 path_cnt;
    longint             path_pos;

    t_cam_pose pose_q [$];
    int        err_cnt;
    int        n_ticks, n_appends, n_clears, n_noise, n_checked, n_wraps;
    int        snd_idle_pct, rcv_idle_pct;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint blend(longint a, longint b, longint r);
        return a + floor_div((b - a) * r, SEG_STEPS);
    endfunction

    // Catmull-Rom segment in Bezier form at six times scale, one-sided end tangents
    function automatic logic [31:0] curve_axis(int ln, int i, longint r);
        longint q0, q1, c0, c1, c2, c3, a, b, c, d, e, v;
        q0 = path_pts[ln][i];
        q1 = path_pts[ln][i+1];
        c0 = 6 * q0;
        c3 = 6 * q1;
        if (i == 0)
            c1 = c0 + 2 * (q1 - q0);
        else
            c1 = c0 + (q1 - longint'(path_pts[ln][i-1]));
        if (i + 2 >= path_cnt)
            c2 = c3 - 2 * (q1 - q0);
        else
            c2 = c3 - (longint'(path_pts[ln][i+2]) - q0);
        a = blend(c0, c1, r);
        b = blend(c1, c2, r);
        c = blend(c2, c3, r);
        d = blend(a, b, r);
        e = blend(b, c, r);
        v = floor_div(blend(d, e, r) + 3, 6);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Advance the shadow path by one accepted transaction; returns 1 if a pose is due
    function automatic bit path_update(t_stim_row row, output t_cam_pose pose);
        longint pos, segs, bgn;
        pose = '0;
        case (row.kind)
            KIND_APPEND: begin
                n_appends++;
                if (path_cnt < NPTS) begin
                    for (int k = 0; k < 6; k++)
                        path_pts[k][path_cnt] = row.crd[k];
                    path_cnt++;
                end
                return 1'b0;
            end
            KIND_CLEAR: begin
                n_clears++;
                path_cnt = 0;
                return 1'b0;
            end
            KIND_TICK: begin
                n_ticks++;
                if (path_cnt < 2) begin
                    pose.status = 1'b1;
                    return 1'b1;
                end
                segs = path_cnt - 1;
                pos = path_pos + longint'($signed(row.step));
                if (pos < 0) begin
                    pos = segs * SEG_STEPS - 1;
                    n_wraps++;
                end
                bgn = pos / SEG_STEPS;
                if (bgn >= segs) begin
                    pos = 1;
                    bgn = 0;
                    n_wraps++;
                end
                path_pos = pos;
                pose.seg = bgn[5:0];
                for (int k = 0; k < 6; k++)
                    pose.crd[k] = curve_axis(k, int'(bgn), pos - bgn * SEG_STEPS);
                return 1'b1;
            end
            default: begin
                n_noise++;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h want %h", $time, what, got, want);
        err_cnt++;
    endtask

    // Receiver: stall at random on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_ready = ($urandom_range(99) >= rcv_idle_pct);
    end

    // Compare every accepted pose with the oldest one expected
    always @(posedge i_clk) begin
        t_cam_pose want;
        logic [5:0][31:0] got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_look_z_out, o_look_y_out, o_look_x_out,
                   o_eye_z_out, o_eye_y_out, o_eye_x_out};
            if (pose_q.size() == 0) begin
                $display("[%0t] result with nothing expected", $time);
                err_cnt++;
            end else begin
                want = pose_q.pop_front();
                n_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_segment_index !== want.seg)
                    report_mismatch("segment_index", 32'(o_segment_index), 32'(want.seg));
                for (int k = 0; k < 6; k++)
                    if (got[k] !== want.crd[k])
                        report_mismatch($sformatf("coord lane %0d", k), got[k], want.crd[k]);
            end
        end
    end

    // Present one transaction, hold it until accepted, then predict
    task automatic send_row(t_stim_row row);
        t_cam_pose pose;
        bit        acc;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_kind      = row.kind;
        i_step      = row.step;
        i_eye_x_in  = row.crd[0];
        i_eye_y_in  = row.crd[1];
        i_eye_z_in  = row.crd[2];
        i_look_x_in = row.crd[3];
        i_look_y_in = row.crd[4];
        i_look_z_in = row.crd[5];
        acc = 1'b0;
        while (!acc) begin
            @(posedge i_clk);
            acc = o_in_ready;
        end
        if (path_update(row, pose))
            pose_q = {pose_q, (row.typed ? row.pose : pose)};
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Hold the sender until every expected pose has been delivered
    task automatic drain_poses();
        while (pose_q.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'($signed($urandom_range(2000)) - 1000) << 16;
            3:       return 32'($signed($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_stim_row mk_row(logic [1:0] kind, logic [4:0] step);
        t_stim_row row;
        row.kind  = kind;
        row.step  = step;
        row.typed = 1'b0;
        row.pose  = '0;
        for (int k = 0; k < 6; k++)
            row.crd[k] = rand_coord();
        return row;
    endfunction

    function automatic t_stim_row mk_point(logic [31:0] val);
        t_stim_row row;
        row = mk_row(KIND_APPEND, 5'd0);
        for (int k = 0; k < 6; k++)
            row.crd[k] = val;
        return row;
    endfunction

    // Tick on a short path: status set, everything else zero
    function automatic t_stim_row mk_short_tick(logic [4:0] step);
        t_stim_row row;
        row = mk_row(KIND_TICK, step);
        row.typed = 1'b1;
        row.pose.status = 1'b1;
        return row;
    endfunction

    function automatic logic [4:0] rand_step();
        return (($urandom_range(9) == 0) ? 5'($urandom) : 5'($signed($urandom_range(18)) - 9));
    endfunction

    initial begin
        t_stim_row dir_tab [$];
        t_stim_row row;
        int        sent, npts, nticks;

        err_cnt = 0;
        n_ticks = 0; n_appends = 0; n_clears = 0; n_noise = 0; n_checked = 0; n_wraps = 0;
        path_cnt = 0;
        path_pos = 0;
        snd_idle_pct = 22;
        rcv_idle_pct = 82;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_kind = KIND_APPEND;
        i_step = '0;
        {i_eye_x_in, i_eye_y_in, i_eye_z_in} = '0;
        {i_look_x_in, i_look_y_in, i_look_z_in} = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: short paths, extreme points, both wraps, clear, dropped kind
        dir_tab = {dir_tab, mk_short_tick(5'd0)};
        dir_tab = {dir_tab, mk_row(KIND_NOP, 5'd3)};
        dir_tab = {dir_tab, mk_point(32'h7fff_ffff)};
        dir_tab = {dir_tab, mk_short_tick(5'd5)};
        dir_tab = {dir_tab, mk_point(32'h8000_0000)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, 5'd9)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, -5'sd9)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, -5'sd16)};
        dir_tab = {dir_tab, mk_point(32'h0000_0000)};
        dir_tab = {dir_tab, mk_point(32'hffff_ffff)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, 5'd15)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, 5'd15)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, 5'sd0)};
        dir_tab = {dir_tab, mk_row(KIND_CLEAR, 5'd0)};
        dir_tab = {dir_tab, mk_short_tick(-5'sd1)};
        dir_tab = {dir_tab, mk_row(KIND_APPEND, 5'd0)};
        dir_tab = {dir_tab, mk_row(KIND_APPEND, 5'd0)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, 5'd15)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, -5'sd16)};
        dir_tab = {dir_tab, mk_row(KIND_TICK, 5'd15)};
        foreach (dir_tab[n]) begin
            send_row(dir_tab[n]);
            if (n == 5)
                drain_poses();
        end
        drain_poses();

        // Random sessions: usually clear, build a path, then play it back
        sent = 0;
        while (sent < 2000) begin
            if (sent >= 1333) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (sent >= 667) begin
                snd_idle_pct = 82;
                rcv_idle_pct = 22;
            end
            if ($urandom_range(3) != 0) begin
                send_row(mk_row(KIND_CLEAR, rand_step()));
                sent++;
            end
            // Mostly short paths; now and then overfill the store
            npts = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
            for (int k = 0; k < npts; k++) begin
                send_row(mk_row(KIND_APPEND, rand_step()));
                sent++;
                if ($urandom_range(19) == 0) begin
                    send_row(mk_row(KIND_NOP, rand_step()));
                    sent++;
                end
            end
            nticks = $urandom_range(3, 30);
            for (int k = 0; k < nticks; k++) begin
                send_row(mk_row(($urandom_range(24) == 0) ? KIND_NOP : KIND_TICK, rand_step()));
                sent++;
            end
        end

        drain_poses();
        repeat (400) @(posedge i_clk);
        $display("Run covered %0d ticks (%0d wraps), %0d appends, %0d clears, %0d dropped.",
                 n_ticks, n_wraps, n_appends, n_clears, n_noise);
        $display("Poses checked: %0d, still pending: %0d", n_checked, pose_q.size());
        if (err_cnt == 0 && pose_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
